/* design/cis_pkg.sv */
// Shared types, constants and helper functions of the case-insensitive substring search.
// No dependencies; every other file of the block refers to it by scoped names.
package cis_pkg;

  // Parameter defaults
  localparam int MAX_NEEDLE_DEF  = 16;
  localparam int LEAD_BYTES_DEF  = 8;
  localparam int SNIPPET_CAP_DEF = 64;

  // Fixed field widths
  localparam int NEEDLE_BYTES = 16;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int LEN_W        = 5;
  localparam int POS_W        = 16;
  localparam int REC_W        = 24;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 2'd2;

  // Character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Result kinds
  localparam logic KIND_SNIPPET = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0]       text_byte;
    logic             end_of_record;
    logic [REC_W-1:0] record_id;
    logic             new_search;
  } in_item_t;

  typedef struct packed {
    logic             item_kind;
    logic [7:0]       snippet_char;
    logic             hit;
    logic [POS_W-1:0] match_position;
    logic [REC_W-1:0] hit_record;
    logic [POS_W-1:0] hits_so_far;
    logic             last_of_run;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic burst_load;  // load next history char into output register
    logic summ_load;   // load record summary into output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic start_burst; // accepted byte is a first hit with a nonzero first snippet char
    logic burst_more;  // another history char follows the current one
    logic in_eor;      // end_of_record of the byte on the input
    logic eor_q;       // end_of_record of the byte being worked on
  } status_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFS : c;
  endfunction

  function automatic logic [7:0] map_ws(input logic [7:0] c);
    map_ws = (c == CH_LF || c == CH_CR || c == CH_TAB) ? CH_SPACE : c;
  endfunction

endpackage

/* design/cis_if.sv */
// Valid/ready channel interfaces for text bytes in and results out.
// Depends on cis_pkg for the payload structs.
interface cis_in_if;
  logic             valid;
  logic             ready;
  cis_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cis_out_if;
  logic               valid;
  logic               ready;
  cis_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/cis_ctrl.sv */
// Sequencer of the substring search: accepts bytes, walks the snippet out, emits summaries.
// Depends on cis_pkg for the command and status structs.
module cis_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cis_pkg::status_t st,
  output cis_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_BURST, S_SUMM} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.burst_load = 1'b0;
    cmd.summ_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = st.out_free;
        cmd.accept = in_valid && st.out_free;
        if (cmd.accept) begin
          if (st.start_burst) begin
            state_nxt = S_BURST;
          end else if (st.in_eor) begin
            state_nxt = S_SUMM;
          end
        end
      end
      S_BURST: begin
        if (st.out_free) begin
          cmd.burst_load = 1'b1;
          if (!st.burst_more) begin
            state_nxt = st.eor_q ? S_SUMM : S_IDLE;
          end
        end
      end
      S_SUMM: begin
        if (st.out_free) begin
          cmd.summ_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/cis_datapath.sv */
// Datapath: needle registers, byte history, match lanes, record state and output register.
// Depends on cis_pkg for structs, constants and the case-fold / whitespace helpers.
module cis_datapath #(
  parameter int MAX_NEEDLE  = cis_pkg::MAX_NEEDLE_DEF,
  parameter int LEAD_BYTES  = cis_pkg::LEAD_BYTES_DEF,
  parameter int SNIPPET_CAP = cis_pkg::SNIPPET_CAP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cis_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  cis_pkg::in_item_t                   in_data,
  input  cis_pkg::cmd_t                       cmd,
  output cis_pkg::status_t                    st,
  input  logic                                out_ready,
  output logic                                out_valid,
  output cis_pkg::out_item_t                  out_data
);

  localparam int HIST_DEPTH = LEAD_BYTES + MAX_NEEDLE;
  localparam int HIST_W     = HIST_DEPTH * 8;
  localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int EM_W       = $clog2(SNIPPET_CAP);
  localparam int POS_W      = cis_pkg::POS_W;
  localparam int LEN_W      = cis_pkg::LEN_W;

  // Configuration
  logic [cis_pkg::CFG_DATA_W-1:0] needle_lo_r, needle_hi_r;
  logic [LEN_W-1:0]               needle_len_r;

  // Record state
  logic [HIST_W-1:0]     hist_r;
  logic [HIST_DEPTH-1:0] zero_r;      // per history byte: byte is zero
  logic [POS_W-1:0]      pos_r;
  logic                  found_r;
  logic [POS_W-1:0]      found_off_r;
  logic [EM_W-1:0]       emitted_r;
  logic                  done_r;
  logic [POS_W-1:0]      hit_total_r;
  logic [cis_pkg::REC_W-1:0] rec_r;
  logic                  eor_r;
  logic [IDX_W-1:0]      k_r;         // history index of next burst char

  logic               out_valid_r;
  cis_pkg::out_item_t out_data_r, out_data_nxt;

  // Combinational
  logic [cis_pkg::NEEDLE_BYTES-1:0][7:0] nb;
  logic [cis_pkg::NEEDLE_BYTES-1:0][7:0] nb_f;
  logic [LEN_W-1:0]      n_eff;
  logic [HIST_W-1:0]     hist_nxt;
  logic [HIST_DEPTH-1:0] zero_nxt;
  logic [MAX_NEEDLE-1:0] lane_ok;
  logic                  enough, match;
  logic [POS_W:0]        off17;
  logic [POS_W-1:0]      off;
  logic [CNT_W-1:0]      lead_c, cnt;
  logic [IDX_W-1:0]      kstart, k_m1;
  logic                  first_zero, start_burst;
  logic [7:0]            c, bchar;
  logic                  acc_char, acc_zero;
  logic [EM_W:0]         emitted_inc;
  logic                  cap_hit, next_zero, burst_more;
  logic                  load;
  logic [POS_W-1:0]      total_base;

  assign c  = in_data.text_byte;
  assign nb = {needle_hi_r, needle_lo_r};

  always_comb begin
    for (int i = 0; i < cis_pkg::NEEDLE_BYTES; i++) begin
      nb_f[i] = cis_pkg::fold_case(nb[i]);
    end
  end

  assign n_eff = (needle_len_r > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : needle_len_r;

  // History after shifting in the current byte; oldest byte falls off the top
  assign hist_nxt = HIST_W'({hist_r, c});
  assign zero_nxt = HIST_DEPTH'({zero_r, c == 8'd0});

  // Lane j compares history byte j against needle byte n-1-j
  always_comb begin
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      lane_ok[j] = (LEN_W'(j) >= n_eff) ||
                   (cis_pkg::fold_case(hist_nxt[j*8 +: 8]) ==
                    nb_f[4'(n_eff - LEN_W'(j) - LEN_W'(1))]);
    end
  end

  assign enough = ({1'b0, pos_r} + (POS_W+1)'(1)) >= (POS_W+1)'(n_eff);
  assign match  = !found_r && (n_eff != '0) && enough && (&lane_ok);
  assign off17  = {1'b0, pos_r} + (POS_W+1)'(1) - (POS_W+1)'(n_eff);
  assign off    = off17[POS_W-1:0];
  assign lead_c = (off > POS_W'(LEAD_BYTES)) ? CNT_W'(LEAD_BYTES) : CNT_W'(off);
  assign cnt    = lead_c + CNT_W'(n_eff);
  assign kstart = IDX_W'(cnt - CNT_W'(1));
  assign first_zero  = zero_nxt[kstart];
  assign start_burst = match && !first_zero;

  // Snippet char straight from the input once the record has matched
  assign acc_char = found_r && !done_r && (c != 8'd0);
  assign acc_zero = found_r && !done_r && (c == 8'd0);

  assign emitted_inc = {1'b0, emitted_r} + (EM_W+1)'(1);
  assign cap_hit     = emitted_inc >= (EM_W+1)'(SNIPPET_CAP - 1);

  // Burst walk over the history, oldest lead byte first
  assign bchar      = hist_r[k_r*8 +: 8];
  assign k_m1       = k_r - IDX_W'(1);
  assign next_zero  = (k_r != '0) && zero_r[k_m1];
  assign burst_more = (k_r != '0) && !cap_hit && !next_zero;

  assign total_base = in_data.new_search ? '0 : hit_total_r;

  assign st.out_free    = !out_valid_r || out_ready;
  assign st.start_burst = start_burst;
  assign st.burst_more  = burst_more;
  assign st.in_eor      = in_data.end_of_record;
  assign st.eor_q       = eor_r;

  assign load = (cmd.accept && acc_char) || cmd.burst_load || cmd.summ_load;

  always_comb begin
    out_data_nxt = '0;
    if (cmd.summ_load) begin
      out_data_nxt.item_kind      = cis_pkg::KIND_SUMMARY;
      out_data_nxt.hit            = found_r;
      out_data_nxt.match_position = found_r ? found_off_r : '0;
      out_data_nxt.hit_record     = rec_r;
      out_data_nxt.hits_so_far    = hit_total_r;
      out_data_nxt.last_of_run    = 1'b1;
    end else if (cmd.burst_load) begin
      out_data_nxt.item_kind    = cis_pkg::KIND_SNIPPET;
      out_data_nxt.snippet_char = cis_pkg::map_ws(bchar);
      out_data_nxt.last_of_run  = !burst_more && !eor_r;
    end else begin
      out_data_nxt.item_kind    = cis_pkg::KIND_SNIPPET;
      out_data_nxt.snippet_char = cis_pkg::map_ws(c);
      out_data_nxt.last_of_run  = !in_data.end_of_record;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_lo_r  <= '0;
      needle_hi_r  <= '0;
      needle_len_r <= '0;
      hist_r       <= '0;
      zero_r       <= '1;
      pos_r        <= '0;
      found_r      <= 1'b0;
      found_off_r  <= '0;
      emitted_r    <= '0;
      done_r       <= 1'b0;
      hit_total_r  <= '0;
      rec_r        <= '0;
      eor_r        <= 1'b0;
      k_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cis_pkg::CFG_NEEDLE_LOW:    needle_lo_r  <= cfg_wdata;
          cis_pkg::CFG_NEEDLE_HIGH:   needle_hi_r  <= cfg_wdata;
          cis_pkg::CFG_NEEDLE_LENGTH: needle_len_r <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end

      out_valid_r <= load || (out_valid_r && !out_ready);

      if (cmd.accept) begin
        hist_r <= hist_nxt;
        zero_r <= zero_nxt;
        rec_r  <= in_data.record_id;
        eor_r  <= in_data.end_of_record;
        if (in_data.end_of_record) begin
          pos_r <= '0;
        end else if (pos_r != cis_pkg::POS_MAX) begin
          pos_r <= pos_r + POS_W'(1);
        end
        if (match && total_base != cis_pkg::POS_MAX) begin
          hit_total_r <= total_base + POS_W'(1);
        end else begin
          hit_total_r <= total_base;
        end
        if (match) begin
          found_r     <= 1'b1;
          found_off_r <= (pos_r == cis_pkg::POS_MAX) ? cis_pkg::POS_MAX : off;
          k_r         <= kstart;
          if (first_zero) begin
            done_r <= 1'b1;
          end
        end
        if (acc_char) begin
          emitted_r <= emitted_inc[EM_W-1:0];
          if (cap_hit) begin
            done_r <= 1'b1;
          end
        end else if (acc_zero) begin
          done_r <= 1'b1;
        end
      end

      if (cmd.burst_load) begin
        emitted_r <= emitted_inc[EM_W-1:0];
        k_r       <= k_m1;
        if (cap_hit || next_zero) begin
          done_r <= 1'b1;
        end
      end

      if (cmd.summ_load) begin
        found_r     <= 1'b0;
        found_off_r <= '0;
        emitted_r   <= '0;
        done_r      <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/case_insensitive_substring_snippet_top.sv */
// Case-insensitive substring search with snippet. A result is registered in the output
// register the cycle after it is produced. First hit of a record: after the accept, one
// snippet char per lead+needle char (up to LEAD_BYTES+MAX_NEEDLE) follows, paced by the
// single output register. End of record adds a summary result. Synchronous reset clears
// needle registers, history, counters.
module case_insensitive_substring_snippet_top #(
  parameter int MAX_NEEDLE  = cis_pkg::MAX_NEEDLE_DEF,
  parameter int LEAD_BYTES  = cis_pkg::LEAD_BYTES_DEF,
  parameter int SNIPPET_CAP = cis_pkg::SNIPPET_CAP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [cis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // text bytes in, results out
  cis_in_if.sink                         in_chan,
  cis_out_if.source                      out_chan
);

  cis_pkg::cmd_t    cmd;
  cis_pkg::status_t st;
  logic             ready;

  // Controller: one transfer in at a time while idle and the output slot is free,
  // then walks snippet and record summary out one result per cycle while slot is free.
  cis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: needle registers, shifting history, parallel compare lanes,
  // per-record counters and the output register.
  cis_datapath #(
    .MAX_NEEDLE  (MAX_NEEDLE),
    .LEAD_BYTES  (LEAD_BYTES),
    .SNIPPET_CAP (SNIPPET_CAP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_chan.data),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.data)
  );

  assign in_chan.ready = ready;

endmodule
